FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the scanline decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/rrd_pkg.sv
// Types, codes and the pixel conversion function of the scanline decoder.
package rrd_pkg;

  localparam logic [2:0] STS_BYTE_TAKEN = 3'd0;
  localparam logic [2:0] STS_PIXEL      = 3'd1;
  localparam logic [2:0] STS_REFUSED    = 3'd2;
  localparam logic [2:0] STS_NO_LINE    = 3'd3;
  localparam logic [2:0] STS_DONE       = 3'd4;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [7:0] RUN_BASE = 8'd128;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CODE,
    PH_VALUE,
    PH_LITERAL
  } phase_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_RUN,
    EX_READ,
    EX_LAST,
    EX_PUSH
  } exec_state_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic [10:0] column;
    logic [9:0]  row;
    logic        last_of_row;
  } result_t;

  // Mantissa byte m with shared exponent byte e as IEEE single bits:
  // m * 2^(e-136), exact, subnormal where small, and zero where e is zero.
  function automatic logic [31:0] chan_bits(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  p;
    logic [9:0]  bsum;
    logic [9:0]  bexp;
    logic [31:0] frac;
    logic [31:0] res;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) p = 3'(i);
    end
    bsum = {7'd0, p} + {2'd0, e};
    bexp = bsum - 10'd9;
    frac = {24'd0, m} << (5'd23 - {2'd0, p});
    if (e == 8'd0 || m == 8'd0) begin
      res = 32'd0;
    end else if (bsum >= 10'd10) begin
      res = {1'b0, bexp[7:0], frac[22:0]};
    end else begin
      res = {24'd0, m} << (e[4:0] + 5'd13);
    end
    return res;
  endfunction

endpackage

FILE: rtl/rgbe_rle_scanline_decoder_core.sv
// Top level of the RGBE run-length scanline decoder.
// The block takes the pixel section of an RGBE image as a stream of beats, each either one
// encoded byte or a request to fetch the next decoded pixel, and answers every input beat
// with exactly one result beat in order. A two-entry input queue takes beats while the
// decode engine works, and a two-entry result queue holds answers until they are popped.
// Each scanline starts with a four-byte header that is skipped; run codes above 128 repeat
// the next byte, other codes copy literal bytes, and the line fills a planar store of four
// times the line width. The value byte of a run is taken and then its repeated bytes (up
// to 127) are written one by one, because the store has a single write port. A fetch takes
// the beat, makes four reads of the single store read port (red, green, blue, exponent
// planes), captures the last read data, and forms the IEEE single results, waiting while
// the result queue is full. Rows are delivered from the bottom row upward, with the image
// height taken as half the width. Writing cfg_line_width restarts the image; a width of
// zero counts as one and widths above MAX_WIDTH are clipped. There is no clearing pass.
`include "assert_macros.svh"
module rgbe_rle_scanline_decoder_core
  import rrd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_line_width,
  input  logic        push,
  output logic        full,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [31:0] out_red_bits,
  output logic [31:0] out_green_bits,
  output logic [31:0] out_blue_bits,
  output logic [10:0] out_column,
  output logic [9:0]  out_row,
  output logic        out_last_of_row
);

  in_item_t in_item, q_item;
  logic     q_empty, q_pop;
  result_t  ex_res, out_res;
  logic     ex_push, res_full;

  assign in_item.action    = in_action;
  assign in_item.data_byte = in_data_byte;

  // Front: accepts input beats and holds them for the engine.
  rrd_fifo #(.DW($bits(in_item_t))) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (in_item),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_item)
  );

  // Back: decodes bytes into the line store and drains pixels.
  rrd_exec #(.MAX_WIDTH(MAX_WIDTH)) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_line_width),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_full   (res_full),
    .res_push   (ex_push),
    .res        (ex_res)
  );

  // Result queue: lets the engine go on while a result waits to be popped.
  rrd_fifo #(.DW($bits(result_t))) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ex_push),
    .din   (ex_res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (out_res)
  );

  assign out_status      = out_res.status;
  assign out_red_bits    = out_res.red_bits;
  assign out_green_bits  = out_res.green_bits;
  assign out_blue_bits   = out_res.blue_bits;
  assign out_column      = out_res.column;
  assign out_row         = out_res.row;
  assign out_last_of_row = out_res.last_of_row;

  `RRD_NEVER(a_push_when_full, clk, rst_n, ex_push && res_full, "result pushed into full queue")
  `RRD_NEVER(a_pop_when_empty, clk, rst_n, q_pop && q_empty, "engine took a beat that was not there")
  `RRD_ASSERT(a_pixel_fields, clk, rst_n, (!empty && out_status != STS_PIXEL) |-> (out_red_bits == 32'd0 && out_column == 11'd0 && out_last_of_row == 1'b0), "non-pixel result carries pixel fields")
  `RRD_ASSERT(a_status_range, clk, rst_n, !empty |-> (out_status <= STS_DONE), "result status out of range")

endmodule

FILE: rtl/rrd_fifo.sv
// Two-entry queue used between the port side and the decode engine.
module rrd_fifo
  import rrd_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] dout
);

  logic [DW-1:0] slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/rrd_exec.sv
// Decode engine: line header skip, run and literal decode, line store and pixel drain.
module rrd_exec
  import rrd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data,
  input  logic        item_valid,
  input  in_item_t    item,
  output logic        item_pop,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = WW + 2;
  localparam int AW = $clog2(4 * MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [7:0] store [4 * MAX_WIDTH];

  exec_state_t st_r, st_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_r, hdr_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic [WW-1:0] width_r;
  logic [WW-1:0] rows_r, rows_nxt;
  logic [CW-1:0] drain_r, drain_nxt;
  logic        ready_r, ready_nxt;
  logic [6:0]  run_r, run_nxt;
  logic [7:0]  runb_r, runb_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]  byte_r [4];
  logic [7:0]  rd_q;

  logic          we;
  logic [7:0]    wd;
  logic [PW-1:0] total;
  logic [PW-1:0] pos_put;
  logic [WW-1:0] drain_inc;
  logic [31:0]   cfg_wide, col_wide, row_wide;
  logic [WW-1:0] cfg_w;
  logic [1:0]    cap_idx;
  logic          start;

  assign total     = {width_r, 2'b00};
  assign drain_inc = WW'(drain_r) + WW'(1);
  assign col_wide  = 32'(drain_r);
  assign row_wide  = 32'(rows_r - WW'(1));
  assign cap_idx   = cnt_r - 2'd1;
  assign start     = item_valid && !res_full;

  always_comb begin
    cfg_wide = {20'd0, cfg_data};
    if (cfg_wide == 32'd0) begin
      cfg_wide = 32'd1;
    end else if (cfg_wide > 32'(MAX_WIDTH)) begin
      cfg_wide = 32'(MAX_WIDTH);
    end
    cfg_w = cfg_wide[WW-1:0];
  end

  // Next state of the engine sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EX_IDLE: begin
        if (start && rows_r != '0) begin
          if (item.action == ACT_FETCH && ready_r) begin
            st_nxt = EX_READ;
          end else if (item.action == ACT_BYTE && !ready_r && phase_r == PH_VALUE
                       && rep_r > RUN_BASE) begin
            st_nxt = EX_RUN;
          end
        end
      end
      EX_RUN:  if (run_r == 7'd1) st_nxt = EX_IDLE;
      EX_READ: if (cnt_r == 2'd3) st_nxt = EX_LAST;
      EX_LAST: st_nxt = EX_PUSH;
      EX_PUSH: if (!res_full) st_nxt = EX_IDLE;
      default: st_nxt = EX_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    pos_nxt   = pos_r;
    rep_nxt   = rep_r;
    rows_nxt  = rows_r;
    drain_nxt = drain_r;
    ready_nxt = ready_r;
    run_nxt   = run_r;
    runb_nxt  = runb_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    we        = 1'b0;
    wd        = item.data_byte;
    pos_put   = pos_r;
    case (st_r)
      EX_IDLE: begin
        if (start) begin
          item_pop = 1'b1;
          res_push = 1'b1;
          if (rows_r == '0) begin
            res.status = STS_DONE;
          end else if (item.action == ACT_FETCH) begin
            if (!ready_r) begin
              res.status = STS_NO_LINE;
            end else begin
              res_push = 1'b0;
              addr_nxt = AW'(drain_r);
              cnt_nxt  = 2'd0;
            end
          end else if (ready_r) begin
            res.status = STS_REFUSED;
          end else begin
            res.status = STS_BYTE_TAKEN;
            case (phase_r)
              PH_HEADER: begin
                if (hdr_r == 2'd3) begin
                  hdr_nxt   = 2'd0;
                  pos_nxt   = '0;
                  phase_nxt = PH_CODE;
                end else begin
                  hdr_nxt = hdr_r + 2'd1;
                end
              end
              PH_CODE: begin
                rep_nxt   = item.data_byte;
                phase_nxt = PH_VALUE;
              end
              default: begin
                if (phase_r == PH_VALUE && rep_r > RUN_BASE) begin
                  run_nxt  = 7'(rep_r - RUN_BASE);
                  runb_nxt = item.data_byte;
                  rep_nxt  = 8'd0;
                end else begin
                  if (pos_r < total) begin
                    we      = 1'b1;
                    pos_put = pos_r + PW'(1);
                  end
                  pos_nxt = pos_put;
                  if (phase_r == PH_VALUE) begin
                    rep_nxt = (rep_r != 8'd0) ? rep_r - 8'd1 : 8'd0;
                  end else begin
                    rep_nxt = (rep_r != 8'd0) ? rep_r - 8'd1 : 8'd0;
                  end
                  if (rep_nxt != 8'd0) begin
                    phase_nxt = PH_LITERAL;
                  end else if (pos_put >= total) begin
                    ready_nxt = 1'b1;
                    drain_nxt = '0;
                    phase_nxt = PH_HEADER;
                    hdr_nxt   = 2'd0;
                  end else begin
                    phase_nxt = PH_CODE;
                  end
                end
              end
            endcase
          end
        end
      end
      EX_RUN: begin
        wd = runb_r;
        if (pos_r < total) begin
          we      = 1'b1;
          pos_put = pos_r + PW'(1);
        end
        pos_nxt = pos_put;
        run_nxt = run_r - 7'd1;
        if (run_r == 7'd1) begin
          if (pos_put >= total) begin
            ready_nxt = 1'b1;
            drain_nxt = '0;
            phase_nxt = PH_HEADER;
            hdr_nxt   = 2'd0;
          end else begin
            phase_nxt = PH_CODE;
          end
        end
      end
      EX_READ: begin
        addr_nxt = AW'(addr_r + AW'(width_r));
        cnt_nxt  = cnt_r + 2'd1;
      end
      EX_PUSH: begin
        if (!res_full) begin
          res_push        = 1'b1;
          res.status      = STS_PIXEL;
          res.red_bits    = chan_bits(byte_r[0], byte_r[3]);
          res.green_bits  = chan_bits(byte_r[1], byte_r[3]);
          res.blue_bits   = chan_bits(byte_r[2], byte_r[3]);
          res.column      = col_wide[10:0];
          res.row         = row_wide[9:0];
          if (drain_inc >= width_r) begin
            res.last_of_row = 1'b1;
            ready_nxt = 1'b0;
            drain_nxt = '0;
            rows_nxt  = rows_r - WW'(1);
            pos_nxt   = '0;
            phase_nxt = PH_HEADER;
            hdr_nxt   = 2'd0;
          end else begin
            drain_nxt = drain_inc[CW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[pos_r[AW-1:0]] <= wd;
    end
    rd_q <= store[addr_r];
  end

  always_ff @(posedge clk) begin
    if (st_r == EX_READ && cnt_r != 2'd0) begin
      byte_r[cap_idx] <= rd_q;
    end
    if (st_r == EX_LAST) begin
      byte_r[3] <= rd_q;
    end
    run_r  <= run_nxt;
    runb_r <= runb_nxt;
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WW'(RST_W);
      rows_r  <= WW'(RST_W / 2);
      st_r    <= EX_IDLE;
      phase_r <= PH_HEADER;
      hdr_r   <= 2'd0;
      pos_r   <= '0;
      rep_r   <= 8'd0;
      drain_r <= '0;
      ready_r <= 1'b0;
    end else if (cfg_we) begin
      width_r <= cfg_w;
      rows_r  <= cfg_w >> 1;
      st_r    <= EX_IDLE;
      phase_r <= PH_HEADER;
      hdr_r   <= 2'd0;
      pos_r   <= '0;
      rep_r   <= 8'd0;
      drain_r <= '0;
      ready_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      pos_r   <= pos_nxt;
      rep_r   <= rep_nxt;
      rows_r  <= rows_nxt;
      drain_r <= drain_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule
